/* sv/smf_pkg.sv */
// smf_pkg: shared types and constants for the sliding window median filter
// used by smf_ctrl, smf_dp and sliding_window_median_filter_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

    // window length register
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd7;

    // controller to datapath commands
    typedef struct packed {
        logic ld_sample;   // write new sample into the ring
        logic rd_en;       // issue a read this cycle
        logic rd_win;      // read source: ring (first pass) or scratch
        logic dv;          // read data valid this cycle
        logic out_load;    // load carry into the output register
    } smf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;    // output register can take a new result
    } smf_status_t;

endpackage

`default_nettype wire

/* sv/sliding_window_median_filter_top.sv */
// sliding_window_median_filter_top: top level, joins controller and datapath
// depends on smf_pkg, smf_ctrl, smf_dp (and smf_ram through smf_dp)
//
// Sliding window median filter. Each transfer on the input channel brings one signed
// sample, which goes into a ring of the last MAX_WINDOW samples (zeros until written);
// one transfer on the output channel returns the lower median of the newest window_len
// samples. window_len of 0 acts as 1, above MAX_WINDOW it saturates; reset value 7.
// Items are processed one at a time by a single compare-exchange unit running bubble
// passes over a scratch RAM with one read per cycle; only the passes needed to settle
// the median position are run, over the first L entries for L from len down to m+1,
// with m = (len-1)/2. The next sample is taken as soon as the previous result sits
// in the output register. The ring needs no clearing pass after reset: per-slot
// written flags make unwritten slots read zero.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_filter_top #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]          median,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [smf_pkg::CFG_W-1:0]         window_len
);

    import smf_pkg::*;

    localparam int IDX_W = $clog2(MAX_WINDOW);

    smf_cmd_t         cmd;
    smf_status_t      status;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] dk;

    smf_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .window_len (window_len),
        .status     (status),
        .cmd        (cmd),
        .k          (k),
        .dk         (dk)
    );

    smf_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .k         (k),
        .dk        (dk),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .median    (median)
    );

endmodule

`default_nettype wire

/* sv/smf_ram.sv */
// smf_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module smf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/smf_ctrl.sv */
// smf_ctrl: sequencer for the median filter (length register, pass and index counters)
// depends on smf_pkg
`timescale 1ns / 1ps
`default_nettype none

module smf_ctrl #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [smf_pkg::CFG_W-1:0]  window_len,
    input  wire smf_pkg::smf_status_t       status,
    output smf_pkg::smf_cmd_t               cmd,
    output logic [$clog2(MAX_WINDOW)-1:0]   k,
    output logic [$clog2(MAX_WINDOW)-1:0]   dk
);

    import smf_pkg::*;

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] window_len_reg;
    logic [LEN_W-1:0] limit_reg, limit_next;
    logic [LEN_W-1:0] stop_reg, stop_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             win_reg, win_next;
    logic             dv_reg;
    logic [IDX_W-1:0] dk_reg;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] eff_m1;
    logic [IDX_W-1:0] last_k;

    // zero length acts as one, too large saturates
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(window_len_reg) > MAX_WINDOW)
        begin
            eff_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = LEN_W'(window_len_reg);
        end
    end

    assign eff_m1 = eff_len - LEN_W'(1);
    assign last_k = IDX_W'(limit_reg - LEN_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        limit_next    = limit_reg;
        stop_next     = stop_reg;
        k_next        = k_reg;
        win_next      = win_reg;
        cmd.ld_sample = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_win    = win_reg;
        cmd.dv        = dv_reg;
        cmd.out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_sample = 1'b1;
                    limit_next    = eff_len;
                    // last pass is the one whose max lands on the lower median
                    stop_next     = (eff_m1 >> 1) + LEN_W'(1);
                    k_next        = '0;
                    win_next      = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
                if (k_reg == last_k)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (limit_reg == stop_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    limit_next = limit_reg - LEN_W'(1);
                    k_next     = '0;
                    win_next   = 1'b0;
                    state_next = S_READ;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_len_reg <= CFG_RESET;
            limit_reg      <= '0;
            stop_reg       <= '0;
            k_reg          <= '0;
            win_reg        <= 1'b0;
            dv_reg         <= 1'b0;
            dk_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            limit_reg <= limit_next;
            stop_reg  <= stop_next;
            k_reg     <= k_next;
            win_reg   <= win_next;
            // read data comes back in the cycle after the address
            dv_reg    <= (state_reg == S_READ);
            dk_reg    <= k_reg;
            if (cfg_valid)
            begin
                window_len_reg <= window_len;
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign k         = k_reg;
    assign dk        = dk_reg;

    a_read_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (dv_reg && dk_reg == $past(k_reg)))
        else $error("read issued without matching data cycle");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output loaded while previous result is stalled");

    a_limit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (limit_reg >= stop_reg && stop_reg != '0
            && 32'(limit_reg) <= MAX_WINDOW))
        else $error("pass limit out of range");

endmodule

`default_nettype wire

/* sv/smf_dp.sv */
// smf_dp: sample ring, sort scratch, compare-exchange unit and output register
// depends on smf_pkg and smf_ram
`timescale 1ns / 1ps
`default_nettype none

module smf_dp #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire smf_pkg::smf_cmd_t                 cmd,
    output smf_pkg::smf_status_t                   status,
    input  wire logic [$clog2(MAX_WINDOW)-1:0]     k,
    input  wire logic [$clog2(MAX_WINDOW)-1:0]     dk,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]          median
);

    import smf_pkg::*;

    localparam int IDX_W = $clog2(MAX_WINDOW);

    logic [IDX_W-1:0]              wptr_reg;
    logic [IDX_W-1:0]              newest_reg;
    logic [MAX_WINDOW-1:0]         valid_reg;
    logic                          win_ok_reg;
    logic signed [SAMPLE_BITS-1:0] carry_reg;
    logic signed [SAMPLE_BITS-1:0] median_reg;
    logic                          out_valid_reg;

    logic [IDX_W:0]                win_sum;
    logic [IDX_W-1:0]              win_raddr;
    logic [SAMPLE_BITS-1:0]        win_rdata;
    logic [SAMPLE_BITS-1:0]        scr_rdata;
    logic signed [SAMPLE_BITS-1:0] data;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic                          scr_we;
    logic [IDX_W-1:0]              scr_waddr;

    // ring slot k places back from the newest sample
    assign win_sum   = {1'b0, newest_reg} + (IDX_W + 1)'(MAX_WINDOW) - {1'b0, k};
    assign win_raddr = (newest_reg >= k) ? (newest_reg - k) : win_sum[IDX_W-1:0];

    smf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.ld_sample),
        .waddr (wptr_reg),
        .wdata (sample),
        .re    (cmd.rd_en && cmd.rd_win),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    smf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_scratch (
        .clk   (clk),
        .we    (scr_we),
        .waddr (scr_waddr),
        .wdata (lo),
        .re    (cmd.rd_en && !cmd.rd_win),
        .raddr (k),
        .rdata (scr_rdata)
    );

    // never-written ring slots read as zero
    assign data = cmd.rd_win ? (win_ok_reg ? $signed(win_rdata) : '0) : $signed(scr_rdata);

    // bubble pass as a running max: smaller one drops back one slot
    always_comb
    begin
        if (data < carry_reg)
        begin
            lo = data;
            hi = carry_reg;
        end
        else
        begin
            lo = carry_reg;
            hi = data;
        end
    end

    assign scr_we    = cmd.dv && (dk != '0);
    assign scr_waddr = dk - IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            newest_reg    <= '0;
            valid_reg     <= '0;
            win_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ld_sample)
            begin
                newest_reg          <= wptr_reg;
                valid_reg[wptr_reg] <= 1'b1;
                wptr_reg <= (wptr_reg == IDX_W'(MAX_WINDOW - 1)) ? '0
                                                                 : wptr_reg + IDX_W'(1);
            end
            if (cmd.rd_en && cmd.rd_win)
            begin
                win_ok_reg <= valid_reg[win_raddr];
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dv)
        begin
            carry_reg <= (dk == '0) ? data : hi;
        end
        if (cmd.out_load)
        begin
            median_reg <= carry_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign median          = median_reg;

    a_newest_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_sample |=> valid_reg[newest_reg])
        else $error("newest ring slot not marked written");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(median_reg)))
        else $error("stalled result lost or overwritten");

endmodule

`default_nettype wire
